/* design/stt_pkg.sv */
// Shared types, codes and constants of the source text tokenizer.
package stt_pkg;

  // Width of the position counters as built; they saturate at all ones.
  localparam int POSITION_BITS = 16;
  localparam int POS_W         = (POSITION_BITS < 16) ? POSITION_BITS : 16;

  // Result queue between the scanner and the token channel.
  localparam int RESULT_DEPTH = 4;
  localparam int PTR_W        = $clog2(RESULT_DEPTH);
  localparam int CNT_W        = $clog2(RESULT_DEPTH + 1);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_STAR       = 8'h2A;

  typedef enum logic [4:0] {
    TK_END        = 5'd0,
    TK_NUMBER     = 5'd1,
    TK_IDENT      = 5'd2,
    TK_STRING     = 5'd3,
    TK_PLUS       = 5'd4,
    TK_MINUS      = 5'd5,
    TK_STAR       = 5'd6,
    TK_SLASH      = 5'd7,
    TK_LPAREN     = 5'd8,
    TK_RPAREN     = 5'd9,
    TK_LBRACE     = 5'd10,
    TK_RBRACE     = 5'd11,
    TK_SEMI       = 5'd12,
    TK_COMMA      = 5'd13,
    TK_COLON      = 5'd14,
    TK_DOT        = 5'd15,
    TK_ASSIGN     = 5'd16,
    TK_LT         = 5'd17,
    TK_GT         = 5'd18,
    TK_BANG       = 5'd19,
    TK_PIPE       = 5'd20,
    TK_AMP        = 5'd21,
    TK_ARROW      = 5'd22,
    TK_PIPE_ARROW = 5'd23,
    TK_EQ         = 5'd24,
    TK_NE         = 5'd25,
    TK_LE         = 5'd26,
    TK_GE         = 5'd27,
    TK_ERROR      = 5'd28
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_OPEN_STRING = 2'd1,
    ERR_BAD_CHAR    = 2'd2
  } error_code_t;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] length;
    logic [15:0] line;
    logic [15:0] column;
    error_code_t error;
    logic [7:0]  bad;
    logic        last;
  } stt_token_t;

  // Tokens produced by one accepted item, in order, towards the result queue.
  typedef struct packed {
    logic [1:0] count;
    stt_token_t slot0;
    stt_token_t slot1;
  } stt_push_t;

endpackage

/* design/stt_byte_if.sv */
// Valid/ready channel that carries source text bytes and the end marker.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

/* design/stt_token_if.sv */
// Valid/ready channel that carries result tokens.
interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_length;
  logic [15:0] end_line;
  logic [15:0] end_column;
  logic [1:0]  error_code;
  logic [7:0]  bad_byte;
  logic        last_of_run;

  modport source(output valid, output token_kind, output token_length, output end_line,
                 output end_column, output error_code, output bad_byte,
                 output last_of_run, input ready);
  modport sink(input valid, input token_kind, input token_length, input end_line,
               input end_column, input error_code, input bad_byte,
               input last_of_run, output ready);
endinterface

/* design/stt_scanner.sv */
// Scanner state, position counters and single-pass token decision per byte.
module stt_scanner import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output stt_push_t  push
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [15:0] {
    MODE_IDLE   = 16'h0001,
    MODE_NUM    = 16'h0002,
    MODE_IDENT  = 16'h0004,
    MODE_STR    = 16'h0008,
    MODE_STRESC = 16'h0010,
    MODE_SLASH  = 16'h0020,
    MODE_LCOM   = 16'h0040,
    MODE_BCOM   = 16'h0080,
    MODE_BSTAR  = 16'h0100,
    MODE_MINUS  = 16'h0200,
    MODE_EQ     = 16'h0400,
    MODE_LT     = 16'h0800,
    MODE_GT     = 16'h1000,
    MODE_BANG   = 16'h2000,
    MODE_PIPE   = 16'h4000,
    MODE_PIPEEQ = 16'h8000
  } scan_mode_t;

  function automatic stt_token_t make_tok(token_kind_t kind, logic [15:0] len,
                                          logic [POS_W-1:0] ln, logic [POS_W-1:0] cl,
                                          error_code_t err, logic [7:0] bad);
    stt_token_t t;
    t.kind   = kind;
    t.length = len;
    t.line   = 16'(ln);
    t.column = 16'(cl);
    t.error  = err;
    t.bad    = bad;
    t.last   = 1'b0;
    return t;
  endfunction

  scan_mode_t       mode, mode_next;
  logic [15:0]      plen, plen_next, grown;
  logic [POS_W-1:0] line, line_next, col, col_next, adv_line, adv_col;

  logic is_digit, is_alpha, is_ident;

  // flush of the held token
  logic        fl_valid;
  token_kind_t fl_kind;
  logic [15:0] fl_len;
  error_code_t fl_err;

  // start of a new token
  scan_mode_t  st_mode;
  logic [15:0] st_plen, st_len;
  logic        st_emit;
  token_kind_t st_kind;
  error_code_t st_err;
  logic [7:0]  st_bad;

  logic       restart;
  logic       a_v, b_v;
  stt_token_t a_tok, b_tok;
  logic [1:0] cnt;

  assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign is_alpha = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                    ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
  assign is_ident = is_alpha || is_digit || (text_byte == CH_UNDERSCORE);

  // Position after consuming the byte, saturating.
  always_comb begin
    if (text_byte == CH_LF) begin
      adv_line = (line == '1) ? line : line + POS_W'(1);
      adv_col  = POS_W'(1);
    end else begin
      adv_line = line;
      adv_col  = (col == '1) ? col : col + POS_W'(1);
    end
  end

  assign grown = (plen == 16'hFFFF) ? plen : plen + 16'd1;

  always_comb begin
    fl_valid = 1'b1;
    fl_kind  = TK_END;
    fl_len   = 16'd1;
    fl_err   = ERR_NONE;
    unique case (mode)
      MODE_NUM:    begin fl_kind = TK_NUMBER; fl_len = plen; end
      MODE_IDENT:  begin fl_kind = TK_IDENT;  fl_len = plen; end
      MODE_STR, MODE_STRESC: begin
        fl_kind = TK_ERROR;
        fl_len  = 16'd0;
        fl_err  = ERR_OPEN_STRING;
      end
      MODE_SLASH:  fl_kind = TK_SLASH;
      MODE_MINUS:  fl_kind = TK_MINUS;
      MODE_EQ:     fl_kind = TK_ASSIGN;
      MODE_LT:     fl_kind = TK_LT;
      MODE_GT:     fl_kind = TK_GT;
      MODE_BANG:   fl_kind = TK_BANG;
      MODE_PIPE:   fl_kind = TK_PIPE;
      MODE_PIPEEQ: begin fl_kind = TK_PIPE; fl_len = 16'd2; end
      default:     fl_valid = 1'b0;
    endcase
  end

  always_comb begin
    st_mode = MODE_IDLE;
    st_plen = 16'd1;
    st_len  = 16'd1;
    st_emit = 1'b0;
    st_kind = TK_END;
    st_err  = ERR_NONE;
    st_bad  = 8'd0;
    unique case (text_byte)
      CH_SPACE, CH_TAB, CH_LF, CH_CR: st_plen = 16'd0;
      CH_DQ:     st_mode = MODE_STR;
      CH_SLASH:  st_mode = MODE_SLASH;
      CH_MINUS:  st_mode = MODE_MINUS;
      CH_EQ:     st_mode = MODE_EQ;
      CH_LT:     st_mode = MODE_LT;
      CH_GT:     st_mode = MODE_GT;
      CH_BANG:   st_mode = MODE_BANG;
      CH_PIPE:   st_mode = MODE_PIPE;
      CH_PLUS:   begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_PLUS;   end
      CH_STAR:   begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_STAR;   end
      CH_LPAREN: begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_LPAREN; end
      CH_RPAREN: begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_RPAREN; end
      CH_LBRACE: begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_LBRACE; end
      CH_RBRACE: begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_RBRACE; end
      CH_SEMI:   begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_SEMI;   end
      CH_COMMA:  begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_COMMA;  end
      CH_COLON:  begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_COLON;  end
      CH_DOT:    begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_DOT;    end
      CH_AMP:    begin st_plen = 16'd0; st_emit = 1'b1; st_kind = TK_AMP;    end
      default: begin
        if (is_digit) begin
          st_mode = MODE_NUM;
        end else if (is_alpha || (text_byte == CH_UNDERSCORE)) begin
          st_mode = MODE_IDENT;
        end else begin
          st_plen = 16'd0;
          st_len  = 16'd0;
          st_emit = 1'b1;
          st_kind = TK_ERROR;
          st_err  = ERR_BAD_CHAR;
          st_bad  = text_byte;
        end
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    plen_next = plen;
    line_next = line;
    col_next  = col;
    restart   = 1'b0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    a_tok     = make_tok(fl_kind, fl_len, line, col, fl_err, 8'd0);
    b_tok     = make_tok(TK_END, 16'd0, line, col, ERR_NONE, 8'd0);
    if (end_of_text) begin
      a_v       = fl_valid;
      b_v       = 1'b1;
      mode_next = MODE_IDLE;
      plen_next = 16'd0;
    end else begin
      unique case (mode)
        MODE_NUM: begin
          if (is_digit) begin
            line_next = adv_line; col_next = adv_col; plen_next = grown;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_ident) begin
            line_next = adv_line; col_next = adv_col; plen_next = grown;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_STR: begin
          line_next = adv_line; col_next = adv_col; plen_next = grown;
          if (text_byte == CH_DQ) begin
            a_v       = 1'b1;
            a_tok     = make_tok(TK_STRING, grown, adv_line, adv_col, ERR_NONE, 8'd0);
            mode_next = MODE_IDLE;
            plen_next = 16'd0;
          end else if (text_byte == CH_BSL) begin
            mode_next = MODE_STRESC;
          end
        end
        MODE_STRESC: begin
          line_next = adv_line; col_next = adv_col; plen_next = grown;
          mode_next = MODE_STR;
        end
        MODE_LCOM: begin
          line_next = adv_line; col_next = adv_col;
          if (text_byte == CH_LF) mode_next = MODE_IDLE;
        end
        MODE_BCOM: begin
          line_next = adv_line; col_next = adv_col;
          if (text_byte == CH_STAR) mode_next = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          line_next = adv_line; col_next = adv_col;
          if (text_byte == CH_SLASH) mode_next = MODE_IDLE;
          else if (text_byte != CH_STAR) mode_next = MODE_BCOM;
        end
        MODE_SLASH: begin
          if (text_byte == CH_SLASH || text_byte == CH_STAR) begin
            line_next = adv_line; col_next = adv_col; plen_next = 16'd0;
            mode_next = (text_byte == CH_SLASH) ? MODE_LCOM : MODE_BCOM;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_PIPE: begin
          if (text_byte == CH_EQ) begin
            line_next = adv_line; col_next = adv_col; plen_next = 16'd2;
            mode_next = MODE_PIPEEQ;
          end else begin
            restart = 1'b1;
          end
        end
        MODE_MINUS, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_PIPEEQ: begin
          if (((mode == MODE_MINUS) || (mode == MODE_PIPEEQ)) ?
              (text_byte == CH_GT) : (text_byte == CH_EQ)) begin
            line_next = adv_line; col_next = adv_col;
            mode_next = MODE_IDLE;
            plen_next = 16'd0;
            a_v       = 1'b1;
            unique case (mode)
              MODE_MINUS: a_tok = make_tok(TK_ARROW, 16'd2, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
              MODE_EQ:    a_tok = make_tok(TK_EQ, 16'd2, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
              MODE_BANG:  a_tok = make_tok(TK_NE, 16'd2, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
              MODE_LT:    a_tok = make_tok(TK_LE, 16'd2, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
              MODE_GT:    a_tok = make_tok(TK_GE, 16'd2, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
              default:    a_tok = make_tok(TK_PIPE_ARROW, 16'd3, adv_line, adv_col,
                                           ERR_NONE, 8'd0);
            endcase
          end else begin
            restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        a_v       = fl_valid;
        a_tok     = make_tok(fl_kind, fl_len, line, col, fl_err, 8'd0);
        line_next = adv_line;
        col_next  = adv_col;
        mode_next = st_mode;
        plen_next = st_plen;
        b_v       = st_emit;
        b_tok     = make_tok(st_kind, st_len, adv_line, adv_col, st_err, st_bad);
      end
    end
  end

  // Pack the produced tokens to the front and mark the last of the run.
  always_comb begin
    cnt        = 2'({1'b0, a_v} + {1'b0, b_v});
    push.slot0 = a_v ? a_tok : b_tok;
    push.slot1 = b_tok;
    push.slot0.last = (cnt == 2'd1);
    push.slot1.last = 1'b1;
    push.count = take ? cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      plen <= 16'd0;
      line <= POS_W'(1);
      col  <= POS_W'(1);
    end else if (take) begin
      mode <= mode_next;
      plen <= plen_next;
      line <= line_next;
      col  <= col_next;
    end
  end

  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    take && end_of_text |=> (mode == MODE_IDLE) && (plen == 16'd0))
    else $error("scanner not idle after end marker");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    take && end_of_text |-> (push.count != 2'd0) &&
      ((push.count == 2'd1) ? (push.slot0.kind == TK_END) : (push.slot1.kind == TK_END)))
    else $error("end marker did not produce an end token last");

  a_comment_no_length: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_LCOM) || (mode == MODE_BCOM) || (mode == MODE_BSTAR) |-> plen == 16'd0)
    else $error("pending length held inside a comment");

endmodule

/* design/stt_result_fifo.sv */
// Four-entry result queue: takes up to two tokens a cycle, delivers one while the sink is ready.
module stt_result_fifo import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  stt_push_t push,
  output logic      room,
  stt_token_if.source tokens
);

  stt_token_t       entry [RESULT_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  stt_token_t       head;

  assign pop  = tokens.valid && tokens.ready;
  assign room = count <= CNT_W'(RESULT_DEPTH - 2);
  assign head = entry[rd_ptr];

  assign tokens.valid        = count != '0;
  assign tokens.token_kind   = head.kind;
  assign tokens.token_length = head.length;
  assign tokens.end_line     = head.line;
  assign tokens.end_column   = head.column;
  assign tokens.error_code   = head.error;
  assign tokens.bad_byte     = head.bad;
  assign tokens.last_of_run  = head.last;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entry[wr_ptr] <= push.slot0;
    if (push.count == 2'd2) entry[wr_ptr + PTR_W'(1)] <= push.slot1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> (count + CNT_W'(push.count)) <= CNT_W'(RESULT_DEPTH))
    else $error("result queue overrun");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RESULT_DEPTH))
    else $error("result queue count out of range");

endmodule

/* design/source_text_tokenizer_core.sv */
// Top level of the source text tokenizer: byte channel in, token channel out.
// Source text arrives as one byte per transfer, and a transfer with end_of_text
// set closes the text: the token still held is flushed and an end token follows.
// Blanks and comments are skipped; each byte yields zero, one or two tokens, the
// last of them marked with last_of_run. A token reports its kind, its length in
// bytes (quotes included, saturating at 65535) and the line and column just
// after its last byte; token text is not returned. Rate: one byte is taken every
// clock while the four-entry result queue holds two tokens or fewer; tokens
// leave one per clock while the sink is ready, so with a ready sink the
// sustained byte rate is one per clock whenever the text yields at most one
// token per byte on average. A token is queued at the transfer of the byte
// that ends it; the scanner decides each byte in one pass of logic from its
// mode register. After the end token the scanner is idle, the position
// counters are kept and further bytes are scanned as more text.
module source_text_tokenizer_core import stt_pkg::*; (
  input  logic clk,
  input  logic rst,
  stt_byte_if.sink    bytes,
  stt_token_if.source tokens
);

  logic      room;
  logic      take;
  stt_push_t push;

  // Take a byte only while the queue can hold the two tokens it may produce.
  assign bytes.ready = room;
  assign take        = bytes.valid && room;

  stt_scanner u_scanner (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_byte   (bytes.text_byte),
    .end_of_text (bytes.end_of_text),
    .push        (push)
  );

  // Hold results here so a stalled token sink does not stop the next transfer.
  stt_result_fifo u_result_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule
